// File: rtl/acep_pkg.sv
// Package for the ANSI color escape parser: command struct, parser mode
// enum, byte codes and the xterm 256-color table. No dependencies.
`timescale 1ns / 1ps

package acep_pkg;

  typedef logic [23:0] color_t;
  typedef color_t rom_t [256];

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_e;

  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_LBRK  = 8'h5b;
  localparam logic [7:0] BYTE_M     = 8'h6d;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam color_t     COLOR_BLACK = 24'h000000;
  localparam color_t     COLOR_WHITE = 24'hffffff;

  localparam logic [2:0] ADDR_START_COLOR = 3'd0;

  // One request handed from the front end to the back end.
  typedef struct packed {
    logic       restart;
    logic       set_color;
    logic       black;
    logic [7:0] value;
    logic       emit_esc;
    logic       emit_byte;
    logic [7:0] data;
  } cmd_t;

  localparam rom_t XTERM_ROM = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000, 24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
    24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00, 24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff,
    24'h000000, 24'h00005f, 24'h000087, 24'h0000af, 24'h0000df, 24'h0000ff, 24'h005f00, 24'h005f5f,
    24'h005f87, 24'h005faf, 24'h005fdf, 24'h005fff, 24'h008700, 24'h00875f, 24'h008787, 24'h0087af,
    24'h0087df, 24'h0087ff, 24'h00af00, 24'h00af5f, 24'h00af87, 24'h00afaf, 24'h00afdf, 24'h00afff,
    24'h00df00, 24'h00df5f, 24'h00df87, 24'h00dfaf, 24'h00dfdf, 24'h00dfff, 24'h00ff00, 24'h00ff5f,
    24'h00ff87, 24'h00ffaf, 24'h00ffdf, 24'h00ffff, 24'h5f0000, 24'h5f005f, 24'h5f0087, 24'h5f00af,
    24'h5f00df, 24'h5f00ff, 24'h5f5f00, 24'h5f5f5f, 24'h5f5f87, 24'h5f5faf, 24'h5f5fdf, 24'h5f5fff,
    24'h5f8700, 24'h5f875f, 24'h5f8787, 24'h5f87af, 24'h5f87df, 24'h5f87ff, 24'h5faf00, 24'h5faf5f,
    24'h5faf87, 24'h5fafaf, 24'h5fafdf, 24'h5fafff, 24'h5fdf00, 24'h5fdf5f, 24'h5fdf87, 24'h5fdfaf,
    24'h5fdfdf, 24'h5fdfff, 24'h5fff00, 24'h5fff5f, 24'h5fff87, 24'h5fffaf, 24'h5fffdf, 24'h5fffff,
    24'h870000, 24'h87005f, 24'h870087, 24'h8700af, 24'h8700df, 24'h8700ff, 24'h875f00, 24'h875f5f,
    24'h875f87, 24'h875faf, 24'h875fdf, 24'h875fff, 24'h878700, 24'h87875f, 24'h878787, 24'h8787af,
    24'h8787df, 24'h8787ff, 24'h87af00, 24'h87af5f, 24'h87af87, 24'h87afaf, 24'h87afdf, 24'h87afff,
    24'h87df00, 24'h87df5f, 24'h87df87, 24'h87dfaf, 24'h87dfdf, 24'h87dfff, 24'h87ff00, 24'h87ff5f,
    24'h87ff87, 24'h87ffaf, 24'h87ffdf, 24'h87ffff, 24'haf0000, 24'haf005f, 24'haf0087, 24'haf00af,
    24'haf00df, 24'haf00ff, 24'haf5f00, 24'haf5f5f, 24'haf5f87, 24'haf5faf, 24'haf5fdf, 24'haf5fff,
    24'haf8700, 24'haf875f, 24'haf8787, 24'haf87af, 24'haf87df, 24'haf87ff, 24'hafaf00, 24'hafaf5f,
    24'hafaf87, 24'hafafaf, 24'hafafdf, 24'hafafff, 24'hafdf00, 24'hafdf5f, 24'hafdf87, 24'hafdfaf,
    24'hafdfdf, 24'hafdfff, 24'hafff00, 24'hafff5f, 24'hafff87, 24'hafffaf, 24'hafffdf, 24'hafffff,
    24'hdf0000, 24'hdf005f, 24'hdf0087, 24'hdf00af, 24'hdf00df, 24'hdf00ff, 24'hdf5f00, 24'hdf5f5f,
    24'hdf5f87, 24'hdf5faf, 24'hdf5fdf, 24'hdf5fff, 24'hdf8700, 24'hdf875f, 24'hdf8787, 24'hdf87af,
    24'hdf87df, 24'hdf87ff, 24'hdfaf00, 24'hdfaf5f, 24'hdfaf87, 24'hdfafaf, 24'hdfafdf, 24'hdfafff,
    24'hdfdf00, 24'hdfdf5f, 24'hdfdf87, 24'hdfdfaf, 24'hdfdfdf, 24'hdfdfff, 24'hdfff00, 24'hdfff5f,
    24'hdfff87, 24'hdfffaf, 24'hdfffdf, 24'hdfffff, 24'hff0000, 24'hff005f, 24'hff0087, 24'hff00af,
    24'hff00df, 24'hff00ff, 24'hff5f00, 24'hff5f5f, 24'hff5f87, 24'hff5faf, 24'hff5fdf, 24'hff5fff,
    24'hff8700, 24'hff875f, 24'hff8787, 24'hff87af, 24'hff87df, 24'hff87ff, 24'hffaf00, 24'hffaf5f,
    24'hffaf87, 24'hffafaf, 24'hffafdf, 24'hffafff, 24'hffdf00, 24'hffdf5f, 24'hffdf87, 24'hffdfaf,
    24'hffdfdf, 24'hffdfff, 24'hffff00, 24'hffff5f, 24'hffff87, 24'hffffaf, 24'hffffdf, 24'hffffff,
    24'h080808, 24'h121212, 24'h1c1c1c, 24'h262626, 24'h303030, 24'h3a3a3a, 24'h444444, 24'h4e4e4e,
    24'h585858, 24'h606060, 24'h666666, 24'h767676, 24'h808080, 24'h8a8a8a, 24'h949494, 24'h9e9e9e,
    24'ha8a8a8, 24'hb2b2b2, 24'hbcbcbc, 24'hc6c6c6, 24'hd0d0d0, 24'hdadada, 24'he4e4e4, 24'heeeeee
  };

endpackage

// File: rtl/acep_front.sv
// Front end of the escape parser: runs the text/ESC/sequence state machine
// and the digit-group tracker, and emits one request per effective byte.
// Depends on acep_pkg.
`timescale 1ns / 1ps

module acep_front import acep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       line_end_i,
  input  logic       restart_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  mode_e      mode_q, mode_d;
  logic       chain_q, chain_d;
  logic [1:0] groups_q, groups_d;
  logic       digits_q, digits_d;
  logic [7:0] group_val_q, group_val_d;
  logic [7:0] prev_val_q, prev_val_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TEXT;
      chain_q     <= 1'b1;
      groups_q    <= 2'd0;
      digits_q    <= 1'b0;
      group_val_q <= 8'd0;
      prev_val_q  <= 8'd0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      chain_q     <= chain_d;
      groups_q    <= groups_d;
      digits_q    <= digits_d;
      group_val_q <= group_val_d;
      prev_val_q  <= prev_val_d;
    end
  end

  always_comb begin
    mode_e      mode_v;
    logic       is_digit;
    logic [7:0] val_x10;
    mode_v      = mode_q;
    chain_d     = chain_q;
    groups_d    = groups_q;
    digits_d    = digits_q;
    group_val_d = group_val_q;
    prev_val_d  = prev_val_q;
    cmd_o       = '0;
    cmd_o.restart = restart_i;
    is_digit    = (in_byte_i >= BYTE_ZERO) && (in_byte_i <= BYTE_NINE);
    if (restart_i) begin
      mode_v      = MODE_TEXT;
      chain_d     = 1'b1;
      groups_d    = 2'd0;
      digits_d    = 1'b0;
      group_val_d = 8'd0;
      prev_val_d  = 8'd0;
    end
    val_x10 = {group_val_d[4:0], 3'b000} + {group_val_d[6:0], 1'b0};
    mode_d  = mode_v;

    case (mode_v)
      MODE_SEQ: begin
        if (in_byte_i == BYTE_M) begin
          cmd_o.set_color = 1'b1;
          cmd_o.black     = !digits_d && (groups_d == 2'd0);
          cmd_o.value     = digits_d ? group_val_d : prev_val_d;
          mode_d          = MODE_TEXT;
          chain_d         = 1'b1;
          groups_d        = 2'd0;
          digits_d        = 1'b0;
          group_val_d     = 8'd0;
          prev_val_d      = 8'd0;
        end else if (chain_d) begin
          if (is_digit) begin
            group_val_d = val_x10 + {4'd0, in_byte_i[3:0]};
            digits_d    = 1'b1;
          end else if ((in_byte_i == BYTE_SEMI) && digits_d && (groups_d != 2'd3)) begin
            prev_val_d  = group_val_d;
            groups_d    = groups_d + 2'd1;
            group_val_d = 8'd0;
            digits_d    = 1'b0;
          end else begin
            chain_d = 1'b0;
          end
        end
      end
      MODE_ESC, MODE_TEXT: begin
        if ((mode_v == MODE_ESC) && (in_byte_i == BYTE_LBRK)) begin
          mode_d      = MODE_SEQ;
          chain_d     = 1'b1;
          groups_d    = 2'd0;
          digits_d    = 1'b0;
          group_val_d = 8'd0;
          prev_val_d  = 8'd0;
        end else begin
          cmd_o.emit_esc = (mode_v == MODE_ESC);
          mode_d         = MODE_TEXT;
          if ((in_byte_i == BYTE_ESC) && !line_end_i) begin
            mode_d = MODE_ESC;
          end else begin
            cmd_o.emit_byte = 1'b1;
            cmd_o.data      = in_byte_i;
          end
        end
      end
      default: begin
        mode_d = MODE_TEXT;
      end
    endcase
  end

  assign push_o = accept_i &&
                  (cmd_o.restart || cmd_o.set_color || cmd_o.emit_esc || cmd_o.emit_byte);

endmodule

// File: rtl/acep_fifo.sv
// Two-entry request queue between the parser front end and the output
// back end. Depends on acep_pkg.
`timescale 1ns / 1ps

module acep_fifo import acep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_d;
    end
  end

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rptr_q];

endmodule

// File: rtl/acep_back.sv
// Back end of the escape parser: applies color changes from the queue,
// looks up the palette and drives the registered output channel.
// Depends on acep_pkg.
`timescale 1ns / 1ps

module acep_back import acep_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  color_t     start_color_i,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output color_t     out_color_o,
  output logic       last_o
);

  function automatic rom_t fold_rom();
    rom_t r;
    for (int i = 0; i < 256; i++) begin
      r[i] = XTERM_ROM[i % PALETTE_ENTRIES];
    end
    return r;
  endfunction

  localparam rom_t PAL = fold_rom();

  logic       phase_q, phase_d;
  color_t     color_q, color_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  color_t     out_color_q, out_color_d;
  logic       last_q, last_d;

  always_comb begin
    logic   load_ok;
    color_t color_v;
    load_ok     = !out_valid_q || out_ready_i;
    phase_d     = phase_q;
    color_d     = color_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_color_d = out_color_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    color_v     = color_q;
    if (!phase_q) begin
      if (head_i.restart) begin
        color_v = start_color_i;
      end
      if (head_i.set_color) begin
        color_v = head_i.black ? COLOR_BLACK : PAL[head_i.value];
      end
    end
    if (head_valid_i && load_ok) begin
      color_d     = color_v;
      out_color_d = color_v;
      if (head_i.emit_esc && !phase_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = BYTE_ESC;
        last_d      = !head_i.emit_byte;
        phase_d     = head_i.emit_byte;
        pop_o       = !head_i.emit_byte;
      end else if (head_i.emit_byte) begin
        out_valid_d = 1'b1;
        out_byte_d  = head_i.data;
        last_d      = 1'b1;
        phase_d     = 1'b0;
        pop_o       = 1'b1;
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      color_q     <= COLOR_WHITE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_color_q <= out_color_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_color_o = out_color_q;
  assign last_o      = last_q;

endmodule

// File: rtl/ansi_color_escape_parser.sv
// ANSI SGR 256-color escape parser, top level: config register, front end,
// request queue and back end. Depends on acep_pkg, acep_front, acep_fifo, acep_back.
// A text byte passes through the request queue into the back end's output register.
// Throughput: one input byte per cycle unless the request queue is full; a byte that
// flushes a held ESC yields two results in turn from the single output register.
// Reset: asynchronous, active low; text mode, color and start_color 0xffffff.
`timescale 1ns / 1ps

module ansi_color_escape_parser import acep_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        line_end_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [23:0] out_color_o,
  output logic        last_o
);

  color_t start_color_q;
  logic   accept;
  logic   push, pop, full, empty;
  cmd_t   push_cmd, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_color_q <= COLOR_WHITE;
    end else if (psel && penable && pwrite && (paddr == ADDR_START_COLOR)) begin
      start_color_q <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_START_COLOR) ? {8'd0, start_color_q} : 32'd0;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  acep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .line_end_i (line_end_i),
    .restart_i  (restart_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  acep_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  acep_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_color_i (start_color_q),
    .head_valid_i  (!empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .out_color_o   (out_color_o),
    .last_o        (last_o)
  );

endmodule
